// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, codes and constants of the retry backoff delay block.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int DELAY_BITS_DEF     = 32;
  localparam int ATTEMPT_BITS_DEF   = 8;
  localparam int MULT_FRAC_BITS_DEF = 8;

  localparam int POLICY_BITS    = 3;
  localparam int MULT_BITS      = 16;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int MUL_CHUNK_BITS = 48;

  localparam logic [POLICY_BITS-1:0] POL_NONE   = 3'd0;
  localparam logic [POLICY_BITS-1:0] POL_FIXED  = 3'd1;
  localparam logic [POLICY_BITS-1:0] POL_LINEAR = 3'd2;
  localparam logic [POLICY_BITS-1:0] POL_EXP    = 3'd3;
  localparam logic [POLICY_BITS-1:0] POL_FIB    = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_POLICY      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_DELAY  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MULTIPLIER  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DELAY   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ATTEMPT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_USE_BREAKER = 3'd5;

  localparam int POLICY_RST      = 3;
  localparam int BASE_DELAY_RST  = 100;
  localparam int MULTIPLIER_RST  = 512;
  localparam int MAX_DELAY_RST   = 30000;
  localparam int MAX_ATTEMPT_RST = 3;
  localparam int USE_BREAKER_RST = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic work_done;
  } status_t;

endpackage

// ===== rtl/retry_backoff_delay.sv =====
// ----------------------------------------------------------------------------
// retry_backoff_delay
// Retry delay and retry decision for a failed attempt, under a none, fixed,
// linear, exponential or Fibonacci policy, clamped to a maximum delay.
//
//   channel  dir  fields (low bit up)
//   in_      in   tdata: attempt, error_present, breaker_open
//   out_     out  tdata: wait_ms, retry_allowed
//   cfg_     in   cfg_index, cfg_data (policy .. use_breaker, index 0..5)
//
// Linear and Fibonacci take one saturating add per term and end early at
// the clamp; exponential takes one 48x16 partial product per cycle in the
// multiply-accumulate unit. Reset is synchronous; no clearing pass. The
// next item is taken while a result waits on out_; a stalled result holds
// the controller in finish.
// ----------------------------------------------------------------------------
module retry_backoff_delay #(
  parameter int DELAY_BITS     = rbd_pkg::DELAY_BITS_DEF,
  parameter int ATTEMPT_BITS   = rbd_pkg::ATTEMPT_BITS_DEF,
  parameter int MULT_FRAC_BITS = rbd_pkg::MULT_FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // attempt, error_present, breaker_open
  input  logic [((ATTEMPT_BITS + 2 + 7) / 8) * 8-1:0] in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // wait_ms, retry_allowed
  output logic [((DELAY_BITS + 1 + 7) / 8) * 8-1:0]   out_tdata,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_BITS-1:0]           cfg_index,
  input  logic [DELAY_BITS-1:0]                      cfg_data
);
  import rbd_pkg::*;

  localparam int OUT_W = ((DELAY_BITS + 1 + 7) / 8) * 8;

  logic [POLICY_BITS-1:0]  policy;
  logic [DELAY_BITS-1:0]   base_wait;
  logic [MULT_BITS-1:0]    mult_factor;
  logic [DELAY_BITS-1:0]   max_wait;
  logic [ATTEMPT_BITS-1:0] max_attempts;
  logic                    use_breaker;
  cmd_t                    cmd;
  status_t                 status;
  logic [DELAY_BITS-1:0]   wait_ms;
  logic                    retry_allowed;

  rbd_cfg #(
    .DELAY_BITS  (DELAY_BITS),
    .ATTEMPT_BITS(ATTEMPT_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .policy      (policy),
    .base_wait   (base_wait),
    .mult_factor (mult_factor),
    .max_wait    (max_wait),
    .max_attempts(max_attempts),
    .use_breaker (use_breaker)
  );

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rbd_dpath #(
    .DELAY_BITS    (DELAY_BITS),
    .ATTEMPT_BITS  (ATTEMPT_BITS),
    .MULT_FRAC_BITS(MULT_FRAC_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_attempt      (in_tdata[ATTEMPT_BITS-1:0]),
    .in_error_present(in_tdata[ATTEMPT_BITS]),
    .in_breaker_open (in_tdata[ATTEMPT_BITS+1]),
    .policy          (policy),
    .base_wait       (base_wait),
    .mult_factor     (mult_factor),
    .max_wait        (max_wait),
    .max_attempts    (max_attempts),
    .use_breaker     (use_breaker),
    .wait_ms         (wait_ms),
    .retry_allowed   (retry_allowed)
  );

  assign out_tdata = OUT_W'({retry_allowed, wait_ms});

endmodule

// ===== rtl/rbd_cfg.sv =====
// ----------------------------------------------------------------------------
// rbd_cfg
// Configuration register file, written by index over the cfg channel.
// ----------------------------------------------------------------------------
module rbd_cfg #(
  parameter int DELAY_BITS   = rbd_pkg::DELAY_BITS_DEF,
  parameter int ATTEMPT_BITS = rbd_pkg::ATTEMPT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DELAY_BITS-1:0]            cfg_data,
  output logic [rbd_pkg::POLICY_BITS-1:0]  policy,
  output logic [DELAY_BITS-1:0]            base_wait,
  output logic [rbd_pkg::MULT_BITS-1:0]    mult_factor,
  output logic [DELAY_BITS-1:0]            max_wait,
  output logic [ATTEMPT_BITS-1:0]          max_attempts,
  output logic                             use_breaker
);
  import rbd_pkg::*;

  logic [POLICY_BITS-1:0]  policy_r;
  logic [DELAY_BITS-1:0]   base_r;
  logic [MULT_BITS-1:0]    mult_r;
  logic [DELAY_BITS-1:0]   max_delay_r;
  logic [ATTEMPT_BITS-1:0] max_att_r;
  logic                    breaker_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POLICY_BITS'(POLICY_RST);
      base_r      <= DELAY_BITS'(BASE_DELAY_RST);
      mult_r      <= MULT_BITS'(MULTIPLIER_RST);
      max_delay_r <= DELAY_BITS'(MAX_DELAY_RST);
      max_att_r   <= ATTEMPT_BITS'(MAX_ATTEMPT_RST);
      breaker_r   <= 1'(USE_BREAKER_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLICY:      policy_r    <= cfg_data[POLICY_BITS-1:0];
        REG_BASE_DELAY:  base_r      <= cfg_data;
        REG_MULTIPLIER:  mult_r      <= cfg_data[MULT_BITS-1:0];
        REG_MAX_DELAY:   max_delay_r <= cfg_data;
        REG_MAX_ATTEMPT: max_att_r   <= cfg_data[ATTEMPT_BITS-1:0];
        REG_USE_BREAKER: breaker_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign policy       = policy_r;
  assign base_wait    = base_r;
  assign mult_factor  = mult_r;
  assign max_wait     = max_delay_r;
  assign max_attempts = max_att_r;
  assign use_breaker  = breaker_r;

endmodule

// ===== rtl/rbd_dpath.sv =====
// ----------------------------------------------------------------------------
// rbd_dpath
// Delay datapath: chunked multiply-accumulate for exponential growth,
// saturating adder for linear and Fibonacci series, result register.
// ----------------------------------------------------------------------------
module rbd_dpath #(
  parameter int DELAY_BITS     = rbd_pkg::DELAY_BITS_DEF,
  parameter int ATTEMPT_BITS   = rbd_pkg::ATTEMPT_BITS_DEF,
  parameter int MULT_FRAC_BITS = rbd_pkg::MULT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rbd_pkg::cmd_t                   cmd,
  output rbd_pkg::status_t                status,
  input  logic [ATTEMPT_BITS-1:0]         in_attempt,
  input  logic                            in_error_present,
  input  logic                            in_breaker_open,
  input  logic [rbd_pkg::POLICY_BITS-1:0] policy,
  input  logic [DELAY_BITS-1:0]           base_wait,
  input  logic [rbd_pkg::MULT_BITS-1:0]   mult_factor,
  input  logic [DELAY_BITS-1:0]           max_wait,
  input  logic [ATTEMPT_BITS-1:0]         max_attempts,
  input  logic                            use_breaker,
  output logic [DELAY_BITS-1:0]           wait_ms,
  output logic                            retry_allowed
);
  import rbd_pkg::*;

  localparam int VIN_W   = DELAY_BITS + FRAC_BITS;
  localparam int NCH     = (VIN_W + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
  localparam int PAD_W   = NCH * MUL_CHUNK_BITS;
  localparam int PROD_W  = MUL_CHUNK_BITS + MULT_BITS;
  localparam int ACC_W   = PAD_W + MULT_BITS;
  localparam int VAL_W   = VIN_W + MULT_BITS - MULT_FRAC_BITS;
  localparam int WHOLE_W = VAL_W - FRAC_BITS;
  localparam int CI_W    = (NCH > 1) ? $clog2(NCH) : 1;

  logic [ATTEMPT_BITS-1:0]   att_r;
  logic [ATTEMPT_BITS-1:0]   cnt_r;
  logic [CI_W-1:0]           chunk_r;
  logic                      retry_r;
  logic [ACC_W-1:0]          acc_r;
  logic [VAL_W-1:0]          val_r;
  logic [DELAY_BITS-1:0]     prev_r;
  logic [DELAY_BITS-1:0]     cur_r;
  logic [DELAY_BITS-1:0]     dout_delay_r;
  logic                      dout_retry_r;

  logic [ACC_W-1:0]          acc_nxt;
  logic [WHOLE_W-1:0]        whole;
  logic [WHOLE_W-1:0]        cap_w;
  logic [PAD_W-1:0]          vpad;
  logic [MUL_CHUNK_BITS-1:0] mul_a;
  logic [PROD_W-1:0]         prod;
  logic                      growing;
  logic                      exp_mode;
  logic                      add_mode;
  logic                      chunk_last;
  logic                      exp_done;
  logic                      add_done;
  logic [DELAY_BITS:0]       add_sum;
  logic [DELAY_BITS-1:0]     add_sat;
  logic [DELAY_BITS-1:0]     res_delay;
  logic                      retry_ok;

  assign whole      = val_r[VAL_W-1:FRAC_BITS];
  assign cap_w      = WHOLE_W'(max_wait);
  assign growing    = (mult_factor >> MULT_FRAC_BITS) != '0;
  assign exp_mode   = (policy == POL_EXP);
  assign add_mode   = (policy == POL_LINEAR) || (policy == POL_FIB);
  assign chunk_last = (chunk_r == CI_W'(NCH - 1));

  // one chunk of the fixed-point value times the multiplier per cycle
  assign vpad    = PAD_W'(val_r[VIN_W-1:0]);
  assign mul_a   = vpad[chunk_r * MUL_CHUNK_BITS +: MUL_CHUNK_BITS];
  assign prod    = PROD_W'(mul_a) * PROD_W'(mult_factor);
  assign acc_nxt = acc_r + (ACC_W'(prod) << (chunk_r * MUL_CHUNK_BITS));

  assign exp_done = (cnt_r == att_r) || (growing && (whole >= cap_w)) || (val_r == '0);

  always_comb begin
    if (policy == POL_LINEAR) begin
      add_sum = {1'b0, cur_r} + {1'b0, base_wait};
    end else begin
      add_sum = {1'b0, prev_r} + {1'b0, cur_r};
    end
    add_sat = (add_sum >= {1'b0, max_wait}) ? max_wait : add_sum[DELAY_BITS-1:0];
  end

  assign add_done = (cnt_r == att_r) || (cur_r >= max_wait);

  always_comb begin
    if (exp_mode) begin
      status.work_done = (chunk_r == '0) && exp_done;
    end else if (add_mode) begin
      status.work_done = add_done;
    end else begin
      status.work_done = 1'b1;
    end
  end

  always_comb begin
    case (policy)
      POL_NONE: res_delay = '0;
      POL_LINEAR, POL_FIB: begin
        res_delay = (cur_r >= max_wait) ? max_wait : cur_r;
      end
      POL_EXP: begin
        res_delay = (whole >= cap_w) ? max_wait : whole[DELAY_BITS-1:0];
      end
      default: begin
        res_delay = (base_wait >= max_wait) ? max_wait : base_wait;
      end
    endcase
  end

  assign retry_ok = (policy != POL_NONE) && (in_attempt < max_attempts) &&
                    !(use_breaker && in_breaker_open) && in_error_present;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_r   <= '0;
      cnt_r   <= '0;
      chunk_r <= '0;
    end else if (cmd.start) begin
      att_r   <= in_attempt;
      cnt_r   <= '0;
      chunk_r <= '0;
    end else if (cmd.step) begin
      if (exp_mode && !chunk_last) begin
        chunk_r <= chunk_r + 1'b1;
      end else begin
        chunk_r <= '0;
        cnt_r   <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      retry_r <= retry_ok;
      acc_r   <= '0;
      val_r   <= VAL_W'({base_wait, {FRAC_BITS{1'b0}}});
      prev_r  <= base_wait;
      cur_r   <= base_wait;
    end else if (cmd.step) begin
      if (exp_mode) begin
        if (chunk_last) begin
          val_r <= acc_nxt[MULT_FRAC_BITS +: VAL_W];
          acc_r <= '0;
        end else begin
          acc_r <= acc_nxt;
        end
      end else begin
        prev_r <= cur_r;
        cur_r  <= add_sat;
      end
    end
    if (cmd.load_out) begin
      dout_delay_r <= res_delay;
      dout_retry_r <= retry_r;
    end
  end

  assign wait_ms       = dout_delay_r;
  assign retry_allowed = dout_retry_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= att_r)
    else $error("step count ran past the attempt number");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (cnt_r == '0) && (chunk_r == '0))
    else $error("counters not cleared on new item");

  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chunk_r <= CI_W'(NCH - 1))
    else $error("chunk index out of range");

endmodule

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// Controller: takes an item, steps the datapath until done, hands the result
// to the output register when it is free.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  rbd_pkg::status_t status,
  output rbd_pkg::cmd_t    cmd
);
  import rbd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_RUN;
      ST_RUN:    if (status.work_done) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      ST_RUN:    cmd.step     = !status.work_done;
      ST_FINISH: cmd.load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == ST_RUN) && !in_tready)
    else $error("input taken while an item is in progress");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !cmd.load_out)
    else $error("pending result overwritten");

endmodule
